[rtl/bdip_pkg.sv]
// Package for the bounded decimal integer parser.
// Holds the character codes, status codes, register indexes and shared types.
// No dependencies; every other file in rtl imports it.
package bdip_pkg;

   localparam int CH_W    = 8;
   localparam int VAL_W   = 64;
   localparam int UPPER_W = 63;
   localparam int ST_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;
   // Width of the multiply-by-ten datapath: 64 bits plus headroom for x10 and the digit.
   localparam int WIDE_W  = 68;

   typedef logic [CH_W-1:0] char_type;
   typedef logic [ST_W-1:0] status_type;

   localparam char_type CH_MINUS   = 8'd45;
   localparam char_type CH_ZERO    = 8'd48;
   localparam char_type CH_NINE    = 8'd57;
   localparam char_type CH_NEWLINE = 8'd10;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_RANGE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TERMINATOR  = 2'd2;

   localparam logic [VAL_W-1:0]   LOWER_LIMIT_RST = 64'h8000_0000_0000_0000;
   localparam logic [UPPER_W-1:0] UPPER_LIMIT_RST = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam char_type           TERMINATOR_RST  = 8'd10;

   typedef enum logic [2:0] {
      PH_START  = 3'b001,
      PH_SIGN   = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

   typedef struct packed {
      logic [VAL_W-1:0]   lower_limit;
      logic [UPPER_W-1:0] upper_limit;
      char_type           terminator;
   } cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic signed [VAL_W-1:0] acc;
      logic                    neg;
   } state_type;

   typedef struct packed {
      logic                    emit;
      status_type              status;
      logic signed [VAL_W-1:0] value;
      logic                    ended_by_newline;
   } result_type;

endpackage

[rtl/bdip_if.sv]
// Channel interfaces of the bounded decimal integer parser: character input
// and result output, each with valid/ready handshake. Depends on bdip_pkg.
interface bdip_req_if;
   import bdip_pkg::*;
   logic     valid;
   logic     ready;
   char_type ch;
   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface bdip_rsp_if;
   import bdip_pkg::*;
   logic                    valid;
   logic                    ready;
   status_type              status;
   logic signed [VAL_W-1:0] value;
   logic                    ended_by_newline;
   modport source (output valid, output status, output value, output ended_by_newline,
                   input ready);
   modport sink   (input valid, input status, input value, input ended_by_newline,
                   output ready);
endinterface

[rtl/bounded_decimal_integer_parser.sv]
// Bounded decimal integer parser, top level.
// A character accepted is held in the input register; when it moves on, its result,
// if any, is written to the result register.
// Throughput: one character per cycle; the input stage stalls only while the result
// register holds a result that is not taken. Synchronous reset sets the limits to
// their full range, the terminator to newline, and clears the parse state.
module bounded_decimal_integer_parser (
   input  logic                            clock,
   input  logic                            reset,
   bdip_req_if.sink                        req_chan,
   bdip_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [bdip_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdip_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bdip_pkg::*;

   cfg_type    cfg;
   logic       in_vld_ff, in_vld_in;
   char_type   in_ch_ff, in_ch_in;
   state_type  st_ff, st_in;
   state_type  st_step;
   result_type res_step;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff, out_in;
   logic       advance;
   logic       req_fire;

   bdip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdip_step u_step (
      .ch  (in_ch_ff),
      .cur (st_ff),
      .cfg (cfg),
      .nxt (st_step),
      .res (res_step)
   );

   // The held character moves on when the result register is free or being drained.
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_ch_in  = in_ch_ff;
      if (req_fire) begin
         in_vld_in = 1'b1;
         in_ch_in  = req_chan.ch;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end

      st_in = advance ? st_step : st_ff;

      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_chan.ready;
      if (advance && res_step.emit) begin
         out_vld_in = 1'b1;
         out_in     = res_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         st_ff.phase <= PH_START;
         st_ff.acc   <= '0;
         st_ff.neg   <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         st_ff      <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff <= in_ch_in;
      out_ff   <= out_in;
   end

   assign rsp_chan.valid            = out_vld_ff;
   assign rsp_chan.status           = out_ff.status;
   assign rsp_chan.value            = out_ff.value;
   assign rsp_chan.ended_by_newline = out_ff.ended_by_newline;

`ifndef SYNTHESIS
   // Every result returns the parser to a clean start for the next number.
   assert property (@(posedge clock) disable iff (reset)
      advance && res_step.emit |=>
         st_ff.phase == PH_START && st_ff.acc == '0 && !st_ff.neg)
      else $error("parse state not cleared after a result");

   // At the start of a number nothing may be left over from the previous one.
   assert property (@(posedge clock) disable iff (reset)
      st_ff.phase == PH_START |-> st_ff.acc == '0 && !st_ff.neg)
      else $error("stale accumulator or sign at start of number");

   // The input side only backs up behind a result that is not being taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("input stalled without a blocked result");

   // A refused or invalid number always reports zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != ST_OK |-> rsp_chan.value == '0)
      else $error("nonzero value on an error result");
`endif

endmodule

[rtl/bdip_csr.sv]
// Configuration registers of the parser: limits and terminator character.
// Depends on bdip_pkg.
module bdip_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bdip_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdip_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output bdip_pkg::cfg_type                   cfg
);
   import bdip_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOWER_LIMIT: cfg_in.lower_limit = csr_wdata;
            CSR_UPPER_LIMIT: cfg_in.upper_limit = csr_wdata[UPPER_W-1:0];
            CSR_TERMINATOR:  cfg_in.terminator  = csr_wdata[CH_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_limit <= LOWER_LIMIT_RST;
         cfg_ff.upper_limit <= UPPER_LIMIT_RST;
         cfg_ff.terminator  <= TERMINATOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/bdip_step.sv]
// Per-character step logic of the parser: next parse state and the result, if any.
// Purely combinational; depends on bdip_pkg.
module bdip_step (
   input  bdip_pkg::char_type   ch,
   input  bdip_pkg::state_type  cur,
   input  bdip_pkg::cfg_type    cfg,
   output bdip_pkg::state_type  nxt,
   output bdip_pkg::result_type res
);
   import bdip_pkg::*;

   logic                     is_digit;
   logic                     is_end;
   logic                     neg_eff;
   logic [3:0]               digit;
   logic signed [WIDE_W-1:0] acc_w;
   logic signed [WIDE_W-1:0] acc_x10;
   logic signed [WIDE_W-1:0] acc_next;
   logic signed [WIDE_W-1:0] bound;
   logic                     refuse;
   logic signed [VAL_W-1:0]  ok_value;

   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_end   = (ch == cfg.terminator) || (ch == CH_NEWLINE);
   assign digit    = 4'(ch - CH_ZERO);

   // The sign only sticks once digits have started; before that a sign seen
   // in the previous character is what counts.
   assign neg_eff = (cur.phase == PH_DIGITS) ? cur.neg : (cur.phase == PH_SIGN);

   // The running value is kept non-positive, so each digit is subtracted.
   // Comparing 10*acc - d against the bound in wide arithmetic covers both
   // the bound/10 pre-check and the final check without a divider.
   assign acc_w    = $signed({{(WIDE_W-VAL_W){cur.acc[VAL_W-1]}}, cur.acc});
   assign acc_x10  = (acc_w <<< 3) + (acc_w <<< 1);
   assign acc_next = acc_x10 - $signed({{(WIDE_W-4){1'b0}}, digit});
   assign bound    = neg_eff ?
                     $signed({{(WIDE_W-VAL_W){cfg.lower_limit[VAL_W-1]}}, cfg.lower_limit}) :
                     -$signed({{(WIDE_W-UPPER_W){1'b0}}, cfg.upper_limit});
   assign refuse   = acc_next < bound;

   assign ok_value = cur.neg ? cur.acc : -cur.acc;

   always_comb begin
      nxt                  = cur;
      res.emit             = 1'b0;
      res.status           = ST_OK;
      res.value            = '0;
      res.ended_by_newline = (ch == CH_NEWLINE);

      if (cur.phase == PH_DIGITS) begin
         if (is_end) begin
            res.emit  = 1'b1;
            res.value = ok_value;
         end else if (!is_digit) begin
            res.emit   = 1'b1;
            res.status = ST_INVALID;
         end else if (refuse) begin
            res.emit   = 1'b1;
            res.status = ST_RANGE;
         end else begin
            nxt.acc = acc_next[VAL_W-1:0];
         end
      end else begin
         if ((cur.phase != PH_SIGN) && (ch == CH_MINUS)) begin
            nxt.neg   = 1'b1;
            nxt.phase = PH_SIGN;
         end else if (!is_digit) begin
            res.emit   = 1'b1;
            res.status = ST_INVALID;
         end else if (is_end) begin
            // A digit that is also the terminator ends the number at zero.
            res.emit = 1'b1;
         end else if (refuse) begin
            res.emit   = 1'b1;
            res.status = ST_RANGE;
         end else begin
            nxt.acc   = acc_next[VAL_W-1:0];
            nxt.neg   = neg_eff;
            nxt.phase = PH_DIGITS;
         end
      end

      if (res.emit) begin
         nxt.phase = PH_START;
         nxt.acc   = '0;
         nxt.neg   = 1'b0;
      end
   end

endmodule

[tb/bounded_decimal_integer_parser_tb.sv]
// Self-checking testbench for bounded_decimal_integer_parser.
// Needs bdip_pkg, the channel interfaces in bdip_if.sv and the parser itself; a
// directed table runs first, then random character streams under changing limits.
module bounded_decimal_integer_parser_tb;
   import bdip_pkg::*;

   localparam int PIPE_SETTLE    = 4;
   localparam int PHASE_CHARS    = 135;
   localparam int RANDOM_PHASES  = 8;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic signed [VAL_W-1:0] MIN_DIV10 = -64'sd922337203685477580;

   typedef struct {
      status_type              status;
      logic signed [VAL_W-1:0] value;
      logic                    ended_by_newline;
   } parse_result_type;

   // A character waiting to be sent, optionally with a hand-written expectation.
   typedef struct {
      char_type         ch;
      bit               fixed;
      parse_result_type want;
   } char_item_type;

   typedef enum {ROW_CHAR, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   data;
      char_type                ch;
      bit                      fixed;
      parse_result_type        want;
   } stim_row_type;

   typedef enum {RX_STEADY, RX_MOSTLY, RX_ALTERNATE, RX_SPARSE} rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bdip_req_if req_bus ();
   bdip_rsp_if rsp_bus ();

   bounded_decimal_integer_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state and its copy of the registers.
   cfg_type                 parse_cfg = '{LOWER_LIMIT_RST, UPPER_LIMIT_RST, TERMINATOR_RST};
   phase_type               parse_phase = PH_START;
   logic signed [VAL_W-1:0] acc_val = '0;
   logic                    neg_seen = 1'b0;

   char_item_type    char_q[$];
   parse_result_type pending_results[$];
   int               error_count = 0;
   int               quiet_cycles = 0;
   bit               req_taken = 1'b0;
   int               burst_left = 0;
   int               gap_left = 0;
   bit               long_hold_request = 1'b0;
   int               hold_left = 0;
   int               pattern_left = 0;
   rx_mode_type      rx_mode = RX_STEADY;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic bit close_number(input status_type st, inout parse_result_type res);
      res.status = st;
      res.value  = (st == ST_OK) ? (neg_seen ? acc_val : -acc_val) : '0;
      parse_phase = PH_START;
      acc_val     = '0;
      neg_seen    = 1'b0;
      return 1'b1;
   endfunction

   // Advances the predictor by one character; returns 1 when a result is due.
   function automatic bit parse_char(input char_type c, output parse_result_type res);
      logic                    is_digit;
      logic                    is_end;
      logic signed [VAL_W-1:0] bound;
      logic signed [VAL_W-1:0] digit;
      logic signed [VAL_W-1:0] next_acc;
      res = '{ST_OK, '0, (c == CH_NEWLINE)};
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      is_end   = (c == parse_cfg.terminator) || (c == CH_NEWLINE);
      if (parse_phase == PH_START) begin
         // The sign wins even when the minus sign is also the terminator.
         if (c == CH_MINUS) begin
            neg_seen    = 1'b1;
            parse_phase = PH_SIGN;
            return 1'b0;
         end
         neg_seen = 1'b0;
      end
      if (parse_phase != PH_DIGITS) begin
         if (!is_digit) return close_number(ST_INVALID, res);
         parse_phase = PH_DIGITS;
         if (is_end) return close_number(ST_OK, res);
      end else begin
         if (is_end) return close_number(ST_OK, res);
         if (!is_digit) return close_number(ST_INVALID, res);
      end
      // The value is built as a non-positive number and checked against the bound.
      bound = neg_seen ? $signed(parse_cfg.lower_limit)
                       : -$signed({1'b0, parse_cfg.upper_limit});
      digit = $signed({56'd0, c}) - $signed({56'd0, CH_ZERO});
      if (acc_val < bound / 64'sd10 || (acc_val == MIN_DIV10 && c == CH_NINE))
         return close_number(ST_RANGE, res);
      next_acc = acc_val * 64'sd10 - digit;
      if (next_acc < bound) return close_number(ST_RANGE, res);
      acc_val = next_acc;
      return 1'b0;
   endfunction

   // Checker, predictor, register shadow and watchdog, all sampled at the rising edge.
   always @(posedge clock) begin
      parse_result_type want;
      parse_result_type seen;
      parse_result_type predicted;
      bit               produced;
      if (!reset) begin
         seen = '{rsp_bus.status, rsp_bus.value, rsp_bus.ended_by_newline};
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result: status %0d value %0d newline %0b",
                           seen.status, seen.value, seen.ended_by_newline);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (seen.status !== want.status || seen.value !== want.value ||
                   seen.ended_by_newline !== want.ended_by_newline) begin
                  if (error_count < 10)
                     $display({"mismatch: expected status %0d value %0d newline %0b,",
                               " got %0d %0d %0b"},
                              want.status, want.value, want.ended_by_newline,
                              seen.status, seen.value, seen.ended_by_newline);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            produced = parse_char(req_bus.ch, predicted);
            if (char_q.size() != 0 && char_q[0].fixed)
               pending_results.push_back(char_q[0].want);
            else if (produced)
               pending_results.push_back(predicted);
            req_taken = 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LOWER_LIMIT: parse_cfg.lower_limit = csr_wdata;
               CSR_UPPER_LIMIT: parse_cfg.upper_limit = csr_wdata[UPPER_W-1:0];
               CSR_TERMINATOR:  parse_cfg.terminator  = csr_wdata[CH_W-1:0];
               default: ;
            endcase
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_decimal_integer_parser_tb: done, errors");
            $finish;
         end
      end
   end

   // Character sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.ch    <= '0;
      end else begin
         if (req_taken) begin
            void'(char_q.pop_front());
            req_taken = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 12);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (char_q.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.ch    <= char_q[0].ch;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver: switches among stall patterns, with one long hold on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (long_hold_request) begin
            hold_left         = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               rx_mode      = rx_mode_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(8, 60);
            end
            pattern_left--;
            case (rx_mode)
               RX_STEADY:    rsp_bus.ready <= 1'b1;
               RX_MOSTLY:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               RX_ALTERNATE: rsp_bus.ready <= pattern_left[0];
               default:      rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic stim_row_type char_row(input char_type c);
      return '{ROW_CHAR, '0, '0, c, 1'b0, '{ST_OK, '0, 1'b0}};
   endfunction

   function automatic stim_row_type check_row(input char_type c, input status_type st,
                                              input logic signed [VAL_W-1:0] v,
                                              input logic nl);
      return '{ROW_CHAR, '0, '0, c, 1'b1, '{st, v, nl}};
   endfunction

   function automatic stim_row_type write_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] data);
      return '{ROW_WRITE, idx, data, '0, 1'b0, '{ST_OK, '0, 1'b0}};
   endfunction

   task automatic offer_char(input char_type c);
      char_q.push_back('{c, 1'b0, '{ST_OK, '0, 1'b0}});
   endtask

   // Waits until every character is taken and every result has come back.
   task automatic wait_idle();
      while (char_q.size() != 0 || req_bus.valid || pending_results.size() != 0)
         @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Picks a magnitude: small, random length, near the active limit, around the limit in its last digit, or anything.
   function automatic logic [63:0] draw_magnitude(input bit neg);
      logic [63:0] lim_mag;
      logic [63:0] scale;
      int          roll;
      int          off;
      lim_mag = neg ? 64'd0 - parse_cfg.lower_limit : {1'b0, parse_cfg.upper_limit};
      roll = $urandom_range(0, 99);
      scale = 64'd1;
      if (roll < 30) return 64'($urandom_range(0, 999));
      if (roll < 55) begin
         repeat ($urandom_range(1, 19)) scale = scale * 64'd10;
         return {$urandom, $urandom} % scale;
      end
      if (roll < 75) begin
         off = $urandom_range(0, 4);
         return (lim_mag + 64'(off) >= 64'd2) ? lim_mag + 64'(off) - 64'd2 : 64'd0;
      end
      // Last digit around the limit, which reaches the most negative value case.
      if (roll < 87) return (lim_mag / 64'd10) * 64'd10 + 64'($urandom_range(0, 9));
      return {$urandom, $urandom};
   endfunction

   task automatic queue_number(input bit neg, input logic [63:0] mag, input int zeros,
                               input char_type end_c);
      char_type    digits[$];
      logic [63:0] m;
      m = mag;
      do begin
         digits.push_front(CH_ZERO + char_type'(m % 64'd10));
         m = m / 64'd10;
      end while (m != 0);
      if (neg) offer_char(CH_MINUS);
      repeat (zeros) offer_char(CH_ZERO);
      foreach (digits[i]) offer_char(digits[i]);
      offer_char(end_c);
   endtask

   initial begin
      stim_row_type          directed[$];
      logic [CSR_DATA_W-1:0] lower_w;
      logic [UPPER_W-1:0]    upper_w;
      char_type              term_w;
      char_type              end_c;
      int                    roll;
      int                    zeros;
      bit                    neg;

      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.ch    = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      directed = '{
         check_row(CH_NEWLINE, ST_INVALID, 64'sd0, 1'b1),
         check_row(8'h00, ST_INVALID, 64'sd0, 1'b0),
         check_row(8'hFF, ST_INVALID, 64'sd0, 1'b0),
         char_row("9"),
         check_row(CH_NEWLINE, ST_OK, 64'sd9, 1'b1),
         char_row(CH_MINUS), char_row("0"), char_row("7"),
         check_row(CH_NEWLINE, ST_OK, -64'sd7, 1'b1),
         char_row("4"),
         check_row("x", ST_INVALID, 64'sd0, 1'b0),
         write_row(CSR_UPPER_LIMIT, 64'd99),
         char_row("1"), char_row("0"),
         check_row("0", ST_RANGE, 64'sd0, 1'b0),
         // The lower limit tightens in the middle of a negative number.
         write_row(CSR_LOWER_LIMIT, -64'sd200),
         char_row(CH_MINUS), char_row("1"),
         write_row(CSR_LOWER_LIMIT, -64'sd15),
         check_row("6", ST_RANGE, 64'sd0, 1'b0),
         write_row(CSR_TERMINATOR, 64'd53),
         check_row("5", ST_OK, 64'sd0, 1'b0),
         char_row("3"),
         check_row("5", ST_OK, 64'sd3, 1'b0),
         write_row(CSR_TERMINATOR, 64'(CH_MINUS)),
         write_row(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF),
         char_row(CH_MINUS), char_row("8"),
         check_row(CH_MINUS, ST_OK, -64'sd8, 1'b0),
         char_row(CH_MINUS),
         check_row(CH_MINUS, ST_INVALID, 64'sd0, 1'b0)
      };

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(directed[i].idx, directed[i].data);
         end else begin
            char_q.push_back('{directed[i].ch, directed[i].fixed, directed[i].want});
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         case (p)
            0: begin
               lower_w = LOWER_LIMIT_RST;
               upper_w = UPPER_LIMIT_RST;
               term_w  = ";";
            end
            1: begin
               lower_w = '0;
               upper_w = '0;
               term_w  = 8'hFF;
            end
            2: begin
               lower_w = '1;
               upper_w = 63'd1;
               term_w  = 8'h00;
            end
            default: begin
               lower_w = ($urandom_range(0, 3) == 0) ? LOWER_LIMIT_RST
                       : 64'd0 - ({$urandom, $urandom} >> $urandom_range(0, 62));
               upper_w = ($urandom_range(0, 3) == 0) ? UPPER_LIMIT_RST
                       : 63'({$urandom, $urandom} >> $urandom_range(1, 62));
               case ($urandom_range(0, 5))
                  0:       term_w = CH_NEWLINE;
                  1:       term_w = " ";
                  2:       term_w = ",";
                  3:       term_w = CH_MINUS;
                  4:       term_w = CH_ZERO + char_type'($urandom_range(0, 9));
                  default: term_w = char_type'($urandom_range(0, 255));
               endcase
            end
         endcase
         // Bits above the upper limit's and terminator's widths carry junk that must be ignored.
         write_reg(CSR_LOWER_LIMIT, lower_w);
         write_reg(CSR_UPPER_LIMIT, {1'($urandom_range(0, 1)), upper_w});
         write_reg(CSR_TERMINATOR, {$urandom, 24'($urandom), term_w});
         if (p % 3 == 2) write_reg(CSR_UNUSED, {$urandom, $urandom});

         while (char_q.size() < PHASE_CHARS) begin
            roll  = $urandom_range(0, 99);
            neg   = 1'($urandom_range(0, 1));
            zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
            if (roll < 72) begin
               end_c = $urandom_range(0, 1) ? parse_cfg.terminator : CH_NEWLINE;
            end else if (roll < 88) begin
               end_c = char_type'($urandom_range(0, 255));
            end else begin
               repeat ($urandom_range(1, 3)) offer_char(char_type'($urandom_range(0, 255)));
               continue;
            end
            queue_number(neg, draw_magnitude(neg), zeros, end_c);
         end
         // Results back up while the sender keeps offering characters.
         if (p == 3) long_hold_request = 1'b1;
      end

      wait_idle();
      if (error_count == 0)
         $display("bounded_decimal_integer_parser_tb: done, clean");
      else
         $display("bounded_decimal_integer_parser_tb: done, errors");
      $finish;
   end

endmodule
